FILE: hdl/ism_pkg.sv
// ----------------------------------------------------------------------------
// ism_pkg: shared types and constants for the interval set membership table
// Item layouts, command and status codes, default sizes.
// ----------------------------------------------------------------------------
package ism_pkg;

  localparam int unsigned NumSetsDef     = 4;
  localparam int unsigned MaxRunsDef     = 64;
  localparam int unsigned OrdinalBitsDef = 16;

  localparam logic [2:0] CmdInsert    = 3'd0;
  localparam logic [2:0] CmdRemove    = 3'd1;
  localparam logic [2:0] CmdTest      = 3'd2;
  localparam logic [2:0] CmdRemoveAll = 3'd3;
  localparam logic [2:0] CmdClear     = 3'd4;

  localparam logic [2:0] StDone     = 3'd0;
  localparam logic [2:0] StPresent  = 3'd1;
  localparam logic [2:0] StAbsent   = 3'd2;
  localparam logic [2:0] StUndecl   = 3'd3;
  localparam logic [2:0] StExcluded = 3'd4;
  localparam logic [2:0] StFull     = 3'd5;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        identity_declared;
    logic [1:0]  set_index;
    logic [15:0] slot_ordinal;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        is_member;
    logic [16:0] set_count;
    logic [6:0]  set_runs;
  } rsp_t;

endpackage

FILE: hdl/ism_run_mem.sv
// ----------------------------------------------------------------------------
// ism_run_mem: run bound storage
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ism_run_mem #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: hdl/interval_set_membership_table_core.sv
// ----------------------------------------------------------------------------
// interval_set_membership_table_core: sorted disjoint run sets, memory based
// Sequencer performs binary search, membership probes and shifts in run memory.
// ----------------------------------------------------------------------------
// channel | direction | handshake                    | payload
// req     | in        | start_i & !busy_o            | req_i (req_t)
// rsp     | out       | done_o, one cycle, no stall  | rsp_o (rsp_t)
// cfg     | in        | cfg_valid_i & cfg_ready_o    | cfg_data_i
//
// Steps per item: probing one set is a binary search (7 halving steps at
// 64 runs), each a read address, data wait and compare, then a probe read.
// Each shifted run is a read, a data wait and a write; up to MaxRuns-1 runs
// move on insert, split or delete. Insert, worst case: exclusion probes of
// up to NumSets sets, main probe, neighbor read, decide, shift, write-back,
// final probe, output. Remove-all repeats probe, shift and write-back for
// every set before the final probe. Clear and undeclared items go straight
// to output. The single read port of the run memory gives one read per cycle,
// with registered read data. Reset clears counts; run memory is not cleared.
// Results cannot be stalled: done_o pulses once per item.
// ----------------------------------------------------------------------------
module interval_set_membership_table_core #(
  parameter int unsigned NumSets     = ism_pkg::NumSetsDef,
  parameter int unsigned MaxRuns     = ism_pkg::MaxRunsDef,
  parameter int unsigned OrdinalBits = ism_pkg::OrdinalBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  ism_pkg::req_t       req_i,
  output logic                done_o,
  output ism_pkg::rsp_t       rsp_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);
  import ism_pkg::*;

  localparam int unsigned SB = (NumSets > 1) ? $clog2(NumSets) : 1;
  localparam int unsigned RB = $clog2(MaxRuns);
  localparam int unsigned CB = $clog2(MaxRuns + 1);
  localparam int unsigned AB = SB + RB;
  localparam int unsigned OB = OrdinalBits;
  localparam logic [OB-1:0] OrdMax = '1;

  typedef enum logic [4:0] {
    S_IDLE, S_SRCH, S_SRCH_W, S_SRCH_R, S_PROBE_W, S_PROBE_R, S_DECIDE,
    S_NB_W, S_NB_R, S_SH_RD, S_SH_W, S_SH_WR, S_FIN_W, S_FIN_R, S_OUT
  } state_e;

  // search purpose
  typedef enum logic [1:0] {P_EXCL, P_MAIN, P_FINAL} purp_e;

  state_e state_q;
  purp_e  purp_q;
  req_t   req_q;
  logic [15:0] excl_q;
  logic [CB-1:0] runs_q [NumSets];
  logic [16:0]   cnt_q  [NumSets];

  logic [SB-1:0] s_q, t_q;
  logic [CB-1:0] lo_q, hi_q, k_q, j_q, end_q;
  logic [2:0] st_q;
  logic any_done_q, any_full_q;
  logic [OB-1:0] x_q;
  logic [2*OB-1:0] cur_q, nb_q;  // cur = run k, nb = run k-1
  logic shift_up_q;              // open gap (copy j-1 -> j) vs close (j+1 -> j)
  logic [2*OB-1:0] fin_wr_q;     // post-shift write value
  logic [CB-1:0] fin_idx_q;
  logic fin_en_q;
  logic [2*OB-1:0] fin2_wr_q;
  logic [CB-1:0] fin2_idx_q;
  logic fin2_en_q;
  logic is_mem_q;

  logic          we;
  logic [AB-1:0] waddr, raddr;
  logic [2*OB-1:0] wdata, rdata;

  ism_run_mem #(.Depth(2 ** AB), .Width(2 * OB)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  function automatic logic [AB-1:0] addr(logic [SB-1:0] s, logic [CB-1:0] i);
    return {s, i[RB-1:0]};
  endfunction

  function automatic logic excl(logic [15:0] m, logic [SB-1:0] a, logic [SB-1:0] b);
    logic [4:0] ai, bi;
    ai = 5'(a);
    bi = 5'(b);
    if (ai >= 5'd4 || bi >= 5'd4) return 1'b0;
    return m[4'(ai * 5'd4 + bi)];
  endfunction

  // set index folded into range by compare and subtract
  function automatic logic [SB-1:0] set_of(logic [1:0] idx);
    logic [4:0] v;
    v = 5'(idx);
    for (int i = 0; i < 4; i++) begin
      if (v >= 5'(NumSets)) v = v - 5'(NumSets);
    end
    return SB'(v);
  endfunction

  logic [CB-1:0] mid;
  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  logic [OB-1:0] rf, rl;
  assign rf = rdata[2*OB-1:OB];
  assign rl = rdata[OB-1:0];

  assign busy_o = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE) && !start_i;

  // combinational memory control
  always_comb begin
    we = 1'b0; waddr = addr(s_q, k_q); wdata = cur_q; raddr = addr(t_q, mid);
    unique case (state_q)
      S_PROBE_W: raddr = addr(t_q, lo_q);
      S_NB_W:    raddr = addr(s_q, k_q - 1'b1);
      // hold the shift source address through the data wait
      S_SH_RD, S_SH_W: raddr = shift_up_q ? addr(s_q, j_q - 1'b1) : addr(s_q, j_q + 1'b1);
      S_SH_WR: begin
        we = 1'b1; waddr = addr(s_q, j_q); wdata = rdata;
      end
      S_FIN_W: begin
        we = fin_en_q; waddr = addr(s_q, fin_idx_q); wdata = fin_wr_q;
      end
      S_FIN_R: begin
        we = fin2_en_q; waddr = addr(s_q, fin2_idx_q); wdata = fin2_wr_q;
      end
      default: ;
    endcase
  end

  logic [SB-1:0] s_in;
  assign s_in = set_of(req_i.set_index);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; purp_q <= P_MAIN; excl_q <= '0; done_o <= 1'b0;
      for (int i = 0; i < NumSets; i++) begin
        runs_q[i] <= '0; cnt_q[i] <= '0;
      end
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (cfg_valid_i && cfg_ready_o) excl_q <= cfg_data_i;
          if (start_i) begin
            req_q <= req_i; s_q <= s_in;
            x_q <= OB'(req_i.slot_ordinal);
            any_done_q <= 1'b0; any_full_q <= 1'b0;
            fin_en_q <= 1'b0; fin2_en_q <= 1'b0;
            st_q <= StDone;
            if (req_i.cmd == CmdClear) begin
              runs_q[s_in] <= '0; cnt_q[s_in] <= '0;
              is_mem_q <= 1'b0; state_q <= S_OUT;
            end else if (!req_i.identity_declared) begin
              st_q <= StUndecl; is_mem_q <= 1'b0; state_q <= S_OUT;
            end else begin
              // insert probes every exclusive set first; remove-all walks sets
              t_q <= (req_i.cmd == CmdRemoveAll) ? '0 :
                     (req_i.cmd == CmdInsert) ? '0 : s_in;
              purp_q <= (req_i.cmd == CmdInsert) ? P_EXCL : P_MAIN;
              if (req_i.cmd == CmdRemoveAll) s_q <= '0;
              lo_q <= '0; state_q <= S_SRCH;
              hi_q <= (req_i.cmd == CmdRemoveAll || req_i.cmd == CmdInsert) ?
                      runs_q[0] : runs_q[s_in];
            end
          end
        end
        S_SRCH: begin
          if (purp_q == P_EXCL && !(excl(excl_q, s_q, t_q) || excl(excl_q, t_q, s_q))) begin
            // not exclusive: skip set
            if (t_q == SB'(NumSets - 1)) begin
              purp_q <= P_MAIN; t_q <= s_q; lo_q <= '0; hi_q <= runs_q[s_q];
            end else begin
              t_q <= t_q + 1'b1; lo_q <= '0; hi_q <= runs_q[t_q + 1'b1];
            end
          end else if (lo_q < hi_q) state_q <= S_SRCH_W;
          else state_q <= S_PROBE_W;
        end
        S_SRCH_W: state_q <= S_SRCH_R;
        S_SRCH_R: begin
          if (rl < x_q) lo_q <= mid + 1'b1; else hi_q <= mid;
          state_q <= S_SRCH;
        end
        S_PROBE_W: begin
          k_q <= lo_q;
          state_q <= S_PROBE_R;
        end
        S_PROBE_R: begin
          cur_q <= rdata;
          unique case (purp_q)
            P_EXCL: begin
              if (k_q < runs_q[t_q] && rf <= x_q) begin
                st_q <= StExcluded; state_q <= S_FIN_W; purp_q <= P_FINAL;
              end else begin
                if (t_q == SB'(NumSets - 1)) begin
                  purp_q <= P_MAIN; t_q <= s_q; hi_q <= runs_q[s_q];
                end else begin
                  t_q <= t_q + 1'b1; hi_q <= runs_q[t_q + 1'b1];
                end
                lo_q <= '0; state_q <= S_SRCH;
              end
            end
            P_MAIN: begin
              s_q <= t_q;
              if (req_q.cmd == CmdInsert) state_q <= (k_q != 0) ? S_NB_W : S_DECIDE;
              else state_q <= S_DECIDE;
            end
            default: begin
              is_mem_q <= (k_q < runs_q[s_q]) && (rf <= x_q);
              if (req_q.cmd != CmdInsert && req_q.cmd != CmdRemove &&
                  req_q.cmd != CmdRemoveAll)
                st_q <= ((k_q < runs_q[s_q]) && (rf <= x_q)) ? StDone : StAbsent;
              state_q <= S_OUT;
            end
          endcase
        end
        S_NB_W: state_q <= S_NB_R;
        S_NB_R: begin nb_q <= rdata; state_q <= S_DECIDE; end
        S_DECIDE: begin
          logic [CB-1:0] n;
          logic hit, below, above;
          logic [OB-1:0] f, l;
          n = runs_q[s_q];
          f = cur_q[2*OB-1:OB]; l = cur_q[OB-1:0];
          hit = (k_q < n) && (f <= x_q);
          below = (k_q != 0) && (nb_q[OB-1:0] + 1'b1 == x_q);
          above = (k_q < n) && (x_q < OrdMax) && (f == x_q + 1'b1);
          purp_q <= P_FINAL; state_q <= S_FIN_W;
          if (req_q.cmd == CmdInsert) begin
            if (hit) st_q <= StPresent;
            else if (below && above) begin
              // merge: run k-1 takes last of k, close gap at k
              fin_en_q <= 1'b1; fin_idx_q <= k_q - 1'b1;
              fin_wr_q <= {nb_q[2*OB-1:OB], l};
              runs_q[s_q] <= n - 1'b1; cnt_q[s_q] <= cnt_q[s_q] + 1'b1;
              shift_up_q <= 1'b0; j_q <= k_q; end_q <= n - 1'b1;
              state_q <= (k_q < n - 1'b1) ? S_SH_RD : S_FIN_W;
            end else if (below) begin
              fin_en_q <= 1'b1; fin_idx_q <= k_q - 1'b1;
              fin_wr_q <= {nb_q[2*OB-1:OB], x_q};
              cnt_q[s_q] <= cnt_q[s_q] + 1'b1;
            end else if (above) begin
              fin_en_q <= 1'b1; fin_idx_q <= k_q; fin_wr_q <= {x_q, l};
              cnt_q[s_q] <= cnt_q[s_q] + 1'b1;
            end else if (n >= CB'(MaxRuns)) st_q <= StFull;
            else begin
              fin_en_q <= 1'b1; fin_idx_q <= k_q; fin_wr_q <= {x_q, x_q};
              runs_q[s_q] <= n + 1'b1; cnt_q[s_q] <= cnt_q[s_q] + 1'b1;
              shift_up_q <= 1'b1; j_q <= n; end_q <= k_q;
              state_q <= (n > k_q) ? S_SH_RD : S_FIN_W;
            end
          end else if (req_q.cmd == CmdRemove || req_q.cmd == CmdRemoveAll) begin
            logic [2:0] r;
            r = StDone;
            if (!hit) r = StAbsent;
            else if (f == x_q && l == x_q) begin
              runs_q[s_q] <= n - 1'b1; cnt_q[s_q] <= cnt_q[s_q] - 1'b1;
              shift_up_q <= 1'b0; j_q <= k_q; end_q <= n - 1'b1;
              state_q <= (k_q < n - 1'b1) ? S_SH_RD : S_FIN_W;
            end else if (f == x_q) begin
              fin_en_q <= 1'b1; fin_idx_q <= k_q; fin_wr_q <= {x_q + 1'b1, l};
              cnt_q[s_q] <= cnt_q[s_q] - 1'b1;
            end else if (l == x_q) begin
              fin_en_q <= 1'b1; fin_idx_q <= k_q; fin_wr_q <= {f, x_q - 1'b1};
              cnt_q[s_q] <= cnt_q[s_q] - 1'b1;
            end else if (n >= CB'(MaxRuns)) r = StFull;
            else begin
              fin_en_q <= 1'b1; fin_idx_q <= k_q; fin_wr_q <= {f, x_q - 1'b1};
              fin2_en_q <= 1'b1; fin2_idx_q <= k_q + 1'b1; fin2_wr_q <= {x_q + 1'b1, l};
              runs_q[s_q] <= n + 1'b1; cnt_q[s_q] <= cnt_q[s_q] - 1'b1;
              shift_up_q <= 1'b1; j_q <= n; end_q <= k_q + 1'b1;
              state_q <= (n > k_q + 1'b1) ? S_SH_RD : S_FIN_W;
            end
            if (req_q.cmd == CmdRemove) st_q <= r;
            else begin
              if (r == StDone) any_done_q <= 1'b1;
              if (r == StFull) any_full_q <= 1'b1;
              purp_q <= P_MAIN;
            end
          end else begin
            st_q <= hit ? StDone : StAbsent;
          end
        end
        S_SH_RD: state_q <= S_SH_W;
        S_SH_W:  state_q <= S_SH_WR;
        S_SH_WR: begin
          if (shift_up_q) begin
            j_q <= j_q - 1'b1;
            state_q <= (j_q - 1'b1 > end_q) ? S_SH_RD : S_FIN_W;
          end else begin
            j_q <= j_q + 1'b1;
            state_q <= (j_q + 1'b1 < end_q) ? S_SH_RD : S_FIN_W;
          end
        end
        S_FIN_W: begin
          fin_en_q <= 1'b0;
          state_q <= S_FIN_R;
        end
        S_FIN_R: begin
          fin2_en_q <= 1'b0;
          if (req_q.cmd == CmdRemoveAll && purp_q == P_MAIN) begin
            if (s_q == SB'(NumSets - 1)) begin
              st_q <= any_full_q ? StFull : (any_done_q ? StDone : StAbsent);
              s_q <= set_of(req_q.set_index); t_q <= set_of(req_q.set_index);
              purp_q <= P_FINAL; lo_q <= '0; hi_q <= runs_q[set_of(req_q.set_index)];
            end else begin
              s_q <= s_q + 1'b1; t_q <= s_q + 1'b1;
              lo_q <= '0; hi_q <= runs_q[s_q + 1'b1];
            end
            state_q <= S_SRCH;
          end else begin
            // final membership probe of addressed set
            purp_q <= P_FINAL; t_q <= s_q; lo_q <= '0; hi_q <= runs_q[s_q];
            state_q <= S_SRCH;
          end
        end
        S_OUT: begin
          done_o <= 1'b1;
          rsp_o.status <= st_q;
          rsp_o.is_member <= is_mem_q;
          rsp_o.set_count <= cnt_q[s_q];
          rsp_o.set_runs <= 7'(runs_q[s_q]);
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("start not taken");
  a_no_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !cfg_ready_o) else $error("cfg while busy");
endmodule

FILE: tb/sv/interval_set_membership_table_checker.sv
// ----------------------------------------------------------------------------
// interval_set_membership_table_checker: result checker for the set table
// Tracks the run tables and the exclusion mask from the observed handshakes,
// predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module interval_set_membership_table_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_i,
  input  ism_pkg::req_t req_i,
  input  logic          done_i,
  input  ism_pkg::rsp_t rsp_i,
  input  logic          cfg_valid_i,
  input  logic          cfg_ready_i,
  input  logic [15:0]   cfg_data_i,
  output int            fail_count_o,
  output int            pending_o
);
  import ism_pkg::*;

  localparam int Sets = NumSetsDef;
  localparam int Runs = MaxRunsDef;
  localparam logic [15:0] OrdMax = 16'hFFFF;

  logic [15:0] excl_mask;
  logic [15:0] lo_q [Sets][Runs];
  logic [15:0] hi_q [Sets][Runs];
  int          nruns [Sets];
  int          nmembers [Sets];
  rsp_t        expected_rsp [$];
  int          errors;

  assign fail_count_o = errors;
  assign pending_o    = expected_rsp.size();

  // first run whose last ordinal is not below x
  function automatic int run_at(int s, logic [15:0] x);
    int lo, hi, mid;
    lo = 0;
    hi = nruns[s];
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (hi_q[s][mid] < x) lo = mid + 1; else hi = mid;
    end
    return lo;
  endfunction

  function automatic bit has_ord(int s, logic [15:0] x);
    int k;
    k = run_at(s, x);
    return k < nruns[s] && lo_q[s][k] <= x;
  endfunction

  function automatic void shift_up(int s, int k);
    for (int i = nruns[s]; i > k; i--) begin
      lo_q[s][i] = lo_q[s][i-1];
      hi_q[s][i] = hi_q[s][i-1];
    end
    nruns[s]++;
  endfunction

  function automatic void shift_down(int s, int k);
    for (int i = k; i < nruns[s] - 1; i++) begin
      lo_q[s][i] = lo_q[s][i+1];
      hi_q[s][i] = hi_q[s][i+1];
    end
    nruns[s]--;
  endfunction

  function automatic logic [2:0] add_ord(int s, logic [15:0] x);
    int k, n;
    bit below, above;
    n = nruns[s];
    for (int t = 0; t < Sets; t++)
      if ((excl_mask[s*4+t] || excl_mask[t*4+s]) && has_ord(t, x)) return StExcluded;
    k = run_at(s, x);
    if (k < n && lo_q[s][k] <= x) return StPresent;
    below = k != 0 && {1'b0, hi_q[s][k-1]} + 17'd1 == {1'b0, x};
    above = k < n && x < OrdMax && lo_q[s][k] == x + 16'd1;
    if (below && above) begin
      hi_q[s][k-1] = hi_q[s][k];
      shift_down(s, k);
    end else if (below) begin
      hi_q[s][k-1] = x;
    end else if (above) begin
      lo_q[s][k] = x;
    end else begin
      if (n >= Runs) return StFull;
      shift_up(s, k);
      lo_q[s][k] = x;
      hi_q[s][k] = x;
    end
    nmembers[s]++;
    return StDone;
  endfunction

  function automatic logic [2:0] drop_ord(int s, logic [15:0] x);
    int k;
    logic [15:0] f, l;
    k = run_at(s, x);
    if (k >= nruns[s] || lo_q[s][k] > x) return StAbsent;
    f = lo_q[s][k];
    l = hi_q[s][k];
    if (f == x && l == x) begin
      shift_down(s, k);
    end else if (f == x) begin
      lo_q[s][k] = x + 16'd1;
    end else if (l == x) begin
      hi_q[s][k] = x - 16'd1;
    end else begin
      if (nruns[s] >= Runs) return StFull;
      shift_up(s, k + 1);
      hi_q[s][k] = x - 16'd1;
      lo_q[s][k+1] = x + 16'd1;
      hi_q[s][k+1] = l;
    end
    nmembers[s]--;
    return StDone;
  endfunction

  function automatic rsp_t apply_cmd(req_t r);
    rsp_t o;
    int s;
    logic [2:0] st, rr;
    bit any_done, any_full;
    s = int'(r.set_index) % Sets;
    st = StDone;
    any_done = 0;
    any_full = 0;
    if (r.cmd == CmdClear) begin
      nruns[s] = 0;
      nmembers[s] = 0;
    end else if (!r.identity_declared) begin
      st = StUndecl;
    end else if (r.cmd == CmdInsert) begin
      st = add_ord(s, r.slot_ordinal);
    end else if (r.cmd == CmdRemove) begin
      st = drop_ord(s, r.slot_ordinal);
    end else if (r.cmd == CmdRemoveAll) begin
      for (int t = 0; t < Sets; t++) begin
        rr = drop_ord(t, r.slot_ordinal);
        if (rr == StDone) any_done = 1;
        if (rr == StFull) any_full = 1;
      end
      st = any_full ? StFull : (any_done ? StDone : StAbsent);
    end else begin
      st = has_ord(s, r.slot_ordinal) ? StDone : StAbsent;
    end
    o.status    = st;
    o.is_member = r.cmd != CmdClear && r.identity_declared && has_ord(s, r.slot_ordinal);
    o.set_count = 17'(nmembers[s]);
    o.set_runs  = 7'(nruns[s]);
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t e;
    if (!rst_ni) begin
      excl_mask <= '0;
      errors = 0;
      expected_rsp.delete();
      for (int s = 0; s < Sets; s++) begin
        nruns[s] = 0;
        nmembers[s] = 0;
      end
    end else begin
      // result first: a new item's result cannot appear in its accept cycle
      if (done_i) begin
        if (expected_rsp.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", rsp_i);
        end else begin
          e = expected_rsp.pop_front();
          if (rsp_i.status !== e.status || rsp_i.is_member !== e.is_member ||
              rsp_i.set_count !== e.set_count || rsp_i.set_runs !== e.set_runs) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected %p actual %p", e, rsp_i);
          end
        end
      end
      if (start_i && !busy_i) expected_rsp.push_back(apply_cmd(req_i));
      if (cfg_valid_i && cfg_ready_i) excl_mask <= cfg_data_i;
    end
  end

endmodule

FILE: tb/sv/interval_set_membership_table_core_test.sv
// ----------------------------------------------------------------------------
// interval_set_membership_table_core_test: stimulus and verdict
// Directed corner cases, then random command streams, mostly over a narrow ordinal
// window so runs merge, split and fill; exclusion settings change between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module interval_set_membership_table_core_test;
  import ism_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  req_t        req_i = '0;
  logic        done_o;
  rsp_t        rsp_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  int          fail_count;
  int          pending;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  interval_set_membership_table_core DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .done_o, .rsp_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  interval_set_membership_table_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .req_i, .done_i(done_o),
    .rsp_i(rsp_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  int burst_left = 0;

  // one item; start stays high across back-to-back items, dropped only on a gap
  task automatic issue(input logic [2:0] c, input bit decl, input logic [1:0] s,
                       input logic [15:0] x);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 150)) : 0;
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    req_i   <= '{cmd: c, identity_declared: decl, set_index: s, slot_ordinal: x};
    start_i <= 1'b1;
    // busy is stable at the falling edge; the next rising edge accepts
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    burst_left--;
  endtask

  // drain results, let the block settle, then write the exclusion mask
  task automatic write_mask(input logic [15:0] m);
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    cfg_data_i  <= m;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // random command mix; lo/hi bound the ordinal window
  task automatic random_phase(input int n, input int lo, input int hi);
    int r;
    logic [2:0] c;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      c = r < 45 ? CmdInsert : r < 70 ? CmdRemove : r < 85 ? CmdTest :
          r < 93 ? CmdRemoveAll : r < 96 ? CmdClear : 3'($urandom_range(5, 7));
      issue(c, $urandom_range(0, 19) != 0, 2'($urandom), 16'($urandom_range(lo, hi)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: edges of the ordinal range, merges, splits, refusals
    issue(CmdInsert, 1, 0, 16'h0000);
    issue(CmdInsert, 1, 0, 16'hFFFF);
    issue(CmdInsert, 1, 0, 16'hFFFE);
    issue(CmdInsert, 1, 0, 16'h0002);
    issue(CmdInsert, 1, 0, 16'h0001);   // joins both neighbors
    issue(CmdInsert, 1, 0, 16'h0001);   // already present
    issue(CmdRemove, 1, 0, 16'h0001);   // split
    issue(CmdRemove, 1, 0, 16'h0000);   // single-member run
    issue(CmdRemove, 1, 0, 16'hFFFF);   // trim top
    issue(CmdRemove, 1, 0, 16'h1234);   // not present
    issue(CmdTest, 1, 0, 16'h0002);
    issue(CmdTest, 0, 0, 16'h0002);     // undeclared
    issue(CmdInsert, 1, 3, 16'h0002);
    issue(CmdRemoveAll, 1, 3, 16'h0002);
    issue(CmdRemoveAll, 1, 1, 16'h5555);
    issue(3'd7, 1, 0, 16'hFFFE);        // unused code acts as test
    issue(CmdClear, 0, 0, 16'hAAAA);    // clear ignores identity
    write_mask(16'hFFFF);               // every set exclusive, itself included
    issue(CmdInsert, 1, 2, 16'h0010);
    issue(CmdInsert, 1, 2, 16'h0010);   // excluded by itself
    issue(CmdInsert, 1, 1, 16'h0010);   // excluded by set 2
    // fill set 1 with 64 isolated runs, then overflow on insert
    write_mask(16'h0000);
    for (int i = 0; i < 64; i++) issue(CmdInsert, 1, 1, 16'(i * 4));
    issue(CmdInsert, 1, 1, 16'd1000);
    issue(CmdInsert, 1, 1, 16'd1);      // merge still fine when full
    issue(CmdRemove, 1, 1, 16'd1);
    issue(CmdInsert, 1, 1, 16'd2);
    issue(CmdInsert, 1, 1, 16'd1);
    issue(CmdRemove, 1, 1, 16'd1);      // trim of a full set
    issue(CmdRemoveAll, 1, 1, 16'd1);

    // random phases across exclusion settings; one waits out all results
    random_phase(500, 0, 200);
    write_mask(16'h8421);
    random_phase(400, 0, 150);
    write_mask(16'($urandom));
    random_phase(400, 0, 400);
    write_mask(16'h0000);
    random_phase(300, 0, 65535);
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    random_phase(400, 65400, 65535);

    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("FAILURE");
    $finish;
  end

endmodule
